@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and codes of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_REVERSE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// what every cell of the row does at a clock edge
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2,
		OP_PULL = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     at;     // cell index equals the point
		logic     beyond; // cell index above the point
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_REV  = 2'd1,
		S_READ = 2'd2
	} state_t;

endpackage

@@ rtl/ple_cmd_if.sv @@
// ----------------------------------------------------------------------------
// ple_cmd_if
// command channel: valid/ready with cmd, position and value
// ----------------------------------------------------------------------------
interface ple_cmd_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic        [4:0]  position;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

@@ rtl/ple_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ple_rsp_if
// result channel: valid/ready with status, element and list length
// ----------------------------------------------------------------------------
interface ple_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] element;
	logic               element_valid;
	logic        [4:0]  length;
	logic               last;

	modport source (
		output valid, output status, output element, output element_valid,
		output length, output last, input ready
	);
	modport sink (
		input valid, input status, input element, input element_valid,
		input length, input last, output ready
	);
endinterface

@@ rtl/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds a value, takes it from a neighbor, the head or the input
// ----------------------------------------------------------------------------
module ple_cell (
	input  logic               clk,
	input  ple_pkg::cell_ctrl_t ctrl,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic signed [31:0] head,
	input  logic signed [31:0] value,
	output logic signed [31:0] data
);
	import ple_pkg::*;

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			OP_HOLD: data_d = data_q;
			OP_INS: begin
				if (ctrl.beyond) data_d = left;
				else if (ctrl.at) data_d = value;
			end
			OP_DEL: begin
				if (ctrl.at || ctrl.beyond) data_d = right;
			end
			OP_PULL: begin
				// below the point shift toward head, the point takes the old head
				if (ctrl.at) data_d = head;
				else if (!ctrl.beyond) data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
endmodule

@@ rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of signed 32-bit values held in a row of cells
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// command   in   valid/ready   cmd, position, value
// result    out  valid/ready   status, element, element_valid, length, last
//
// insert, delete, refused commands, short reverse and empty read out are done at
// the accepting edge, where an insert or delete shifts the row.
// reverse of two or more: the request, then length-1 head-to-point moves, then
// the result.
// read out: the request, then one element per cycle while the result is not
// stalled; the row rotates once through its head.
// one output register parts the sides; a stalled result holds a read out in place
// and holds back the reverse result, but the head-to-point moves go on.
// reset clears the list count and control state; the cell contents and result payload are not reset.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ple_cmd_if.sink      command,
	ple_rsp_if.source    result
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 5) ? CW : 5;

	state_t  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q, ptr_d;

	logic               out_valid_q;
	status_t            status_q;
	logic signed [31:0] element_q;
	logic               element_valid_q;
	logic [4:0]         length_q;
	logic               last_q;

	logic               load;
	logic               load_ok;
	status_t            ld_status;
	logic signed [31:0] ld_element;
	logic               ld_valid;
	logic               ld_last;

	cell_op_t      op_c;
	logic [CW-1:0] point_c;

	logic signed [31:0] cell_data [CAPACITY];
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      count_x;

	assign load_ok = !out_valid_q || result.ready;
	assign command.ready = (state_q == S_IDLE) && load_ok;
	assign pos_x   = XW'(command.position);
	assign count_x = XW'(count_q);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		op_c       = OP_HOLD;
		point_c    = '0;
		load       = 1'b0;
		ld_status  = ST_OK;
		ld_element = '0;
		ld_valid   = 1'b0;
		ld_last    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (command.valid && load_ok) begin
					unique case (cmd_t'(command.cmd))
						CMD_INSERT: begin
							load = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								ld_status = ST_FULL;
							end else if (pos_x > count_x) begin
								ld_status = ST_RANGE;
							end else begin
								op_c    = OP_INS;
								point_c = CW'(command.position);
								count_d = count_q + 1'b1;
							end
						end
						CMD_DELETE: begin
							load = 1'b1;
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else if (pos_x >= count_x) begin
								ld_status = ST_RANGE;
							end else begin
								op_c    = OP_DEL;
								point_c = CW'(command.position);
								count_d = count_q - 1'b1;
							end
						end
						CMD_REVERSE: begin
							if (count_q <= CW'(1)) begin
								load = 1'b1;
							end else begin
								ptr_d   = count_q - 1'b1;
								state_d = S_REV;
							end
						end
						CMD_READ: begin
							if (count_q == '0) begin
								load = 1'b1;
							end else begin
								ptr_d   = '0;
								state_d = S_READ;
							end
						end
						default: load = 1'b1;
					endcase
				end
			end
			S_REV: begin
				// move the head to the point, the point walks down to the head
				if (ptr_q != '0) begin
					op_c    = OP_PULL;
					point_c = ptr_q;
					ptr_d   = ptr_q - 1'b1;
				end else if (load_ok) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				if (load_ok) begin
					load       = 1'b1;
					ld_element = cell_data[0];
					ld_valid   = 1'b1;
					ld_last    = (ptr_q == count_q - 1'b1);
					// rotate so the next element comes to the head
					op_c       = OP_PULL;
					point_c    = count_q - 1'b1;
					ptr_d      = ptr_q + 1'b1;
					if (ld_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctrl_t         ctrl;
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		assign ctrl.op     = op_c;
		assign ctrl.at     = (point_c == CW'(i));
		assign ctrl.beyond = (CW'(i) > point_c);
		if (i == 0) begin : g_first
			assign left_d = cell_data[0];
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_final
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_d),
			.right (right_d),
			.head  (cell_data[0]),
			.value (command.value),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			if (load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q        <= ld_status;
			element_q       <= ld_element;
			element_valid_q <= ld_valid;
			// length is reported modulo 32
			length_q        <= 5'(count_d);
			last_q          <= ld_last;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = status_q;
	assign result.element       = element_q;
	assign result.element_valid = element_valid_q;
	assign result.length        = length_q;
	assign result.last          = last_q;
endmodule
